FILE: sv/fcr_pkg.sv
// fcr_pkg: shared types and constants of the convolution reverb
`timescale 1ns / 1ps

package fcr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int TAPS_W     = 11;
    localparam int IDX_W      = 10;
    localparam int REG_IDX_W  = 2;
    localparam int PROD_W     = 2 * SAMPLE_W;
    // low slice of the tap sum that goes through the wet gain on its own
    localparam int LO_W       = 24;
    localparam int FRAC_SHIFT = 27;
    localparam int DRY_SHIFT  = 15;

    localparam logic signed [GAIN_W-1:0] TAIL_GAIN_RST   = 16'sd4096;
    localparam logic signed [GAIN_W-1:0] DIRECT_GAIN_RST = 16'sd0;
    localparam logic [TAPS_W-1:0]        TAPS_IN_USE_RST = 11'd1024;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    localparam logic [REG_IDX_W-1:0] REG_TAIL_GAIN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIRECT_GAIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAPS_IN_USE = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_GAIN,
        ST_SUM,
        ST_SHIP
    } state_t;

    typedef struct packed {
        logic                       cmd;
        logic [IDX_W-1:0]           coef_index;
        logic signed [SAMPLE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       clipped;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic issue_last;
        logic gain_step;
        logic sum_step;
    } mac_ctl_t;

endpackage

FILE: sv/fcr_stream_if.sv
// fcr_stream_if: valid/ready channel carrying one item per transfer
`timescale 1ns / 1ps

interface fcr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/fir_convolution_reverb.sv
// fir_convolution_reverb: top level, control sequencer and the two tap memories
//
//  channel  dir  payload                          transfer when
//  req      in   cmd, coef_index, value           req.valid & req.ready
//  rsp      out  out_sample, clipped              rsp.valid & rsp.ready
//  cfg      in   cfg_index, cfg_data              cfg_we
//
//  a coefficient load gives no result
//  a sample takes one memory read pair per tap, then pipeline drain, gain, sum
//  and output stage
//  after reset both memories are zeroed while req.ready stays low
//  req.ready is high while idle, even with a result still waiting on rsp;
//  a finished result waits in the last stage while rsp is stalled
`timescale 1ns / 1ps

module fir_convolution_reverb #(
    parameter int TAPS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    fcr_stream_if.sink                       req,
    fcr_stream_if.source                     rsp,
    input  logic                             cfg_we,
    input  logic [fcr_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [fcr_pkg::GAIN_W-1:0]       cfg_data
);

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

    fcr_pkg::state_t                    state_reg;
    fcr_pkg::state_t                    state_next;
    logic signed [fcr_pkg::GAIN_W-1:0]  tail_gain_reg;
    logic signed [fcr_pkg::GAIN_W-1:0]  direct_gain_reg;
    logic [fcr_pkg::TAPS_W-1:0]         taps_reg;
    logic [AW-1:0]                      clr_idx_reg;
    logic [AW-1:0]                      wp_reg;
    logic [AW-1:0]                      j_reg;
    logic [AW-1:0]                      rd_ptr_reg;
    logic signed [fcr_pkg::SAMPLE_W-1:0] sample_reg;
    logic                               out_vld_reg;
    fcr_pkg::out_item_t                 out_data_reg;

    logic                               wr_clear;
    logic                               coef_we;
    logic                               hist_we;
    logic                               out_load;
    logic                               idx_ok;
    logic [AW-1:0]                      eff_last;
    logic [AW-1:0]                      coef_waddr;
    logic [AW-1:0]                      hist_waddr;
    logic [fcr_pkg::SAMPLE_W-1:0]       mem_wdata;
    logic [fcr_pkg::SAMPLE_W-1:0]       coef_rdata;
    logic [fcr_pkg::SAMPLE_W-1:0]       hist_rdata;
    fcr_pkg::mac_ctl_t                  ctl;
    logic                               last_done;
    logic signed [fcr_pkg::SAMPLE_W-1:0] mix_sample;
    logic                               mix_clipped;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_gain_reg   <= fcr_pkg::TAIL_GAIN_RST;
            direct_gain_reg <= fcr_pkg::DIRECT_GAIN_RST;
            taps_reg        <= fcr_pkg::TAPS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcr_pkg::REG_TAIL_GAIN:   tail_gain_reg   <= cfg_data;
                fcr_pkg::REG_DIRECT_GAIN: direct_gain_reg <= cfg_data;
                fcr_pkg::REG_TAPS_IN_USE: taps_reg        <= cfg_data[fcr_pkg::TAPS_W-1:0];
                default:                  ;
            endcase
        end
    end

    // zero count means one tap, anything past the store means all of it
    always_comb
    begin
        if (taps_reg == '0)
        begin
            eff_last = '0;
        end
        else if (32'(taps_reg) > TAPS)
        begin
            eff_last = LAST_ADDR;
        end
        else
        begin
            eff_last = AW'(taps_reg - 11'd1);
        end
    end

    assign idx_ok = 32'(req.data.coef_index) < TAPS;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcr_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_ADDR)
                begin
                    state_next = fcr_pkg::ST_IDLE;
                end
            end
            fcr_pkg::ST_IDLE:
            begin
                if (req.valid && req.data.cmd == fcr_pkg::CMD_SAMPLE)
                begin
                    state_next = fcr_pkg::ST_MAC;
                end
            end
            fcr_pkg::ST_MAC:
            begin
                if (j_reg == eff_last)
                begin
                    state_next = fcr_pkg::ST_DRAIN;
                end
            end
            fcr_pkg::ST_DRAIN:
            begin
                if (last_done)
                begin
                    state_next = fcr_pkg::ST_GAIN;
                end
            end
            fcr_pkg::ST_GAIN: state_next = fcr_pkg::ST_SUM;
            fcr_pkg::ST_SUM:  state_next = fcr_pkg::ST_SHIP;
            fcr_pkg::ST_SHIP:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    state_next = fcr_pkg::ST_IDLE;
                end
            end
            default: state_next = fcr_pkg::ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        wr_clear  = 1'b0;
        coef_we   = 1'b0;
        hist_we   = 1'b0;
        out_load  = 1'b0;
        ctl       = '0;
        case (state_reg)
            fcr_pkg::ST_CLEAR:
            begin
                wr_clear = 1'b1;
                coef_we  = 1'b1;
                hist_we  = 1'b1;
            end
            fcr_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.data.cmd == fcr_pkg::CMD_LOAD)
                    begin
                        coef_we = idx_ok;
                    end
                    else
                    begin
                        hist_we   = 1'b1;
                        ctl.clear = 1'b1;
                    end
                end
            end
            fcr_pkg::ST_MAC:
            begin
                ctl.issue      = 1'b1;
                ctl.issue_last = (j_reg == eff_last);
            end
            fcr_pkg::ST_GAIN: ctl.gain_step = 1'b1;
            fcr_pkg::ST_SUM:  ctl.sum_step  = 1'b1;
            fcr_pkg::ST_SHIP: out_load = !out_vld_reg || rsp.ready;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fcr_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            wp_reg      <= '0;
            j_reg       <= '0;
            rd_ptr_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_clear)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (ctl.clear)
            begin
                // newest sample first, walking back through the history
                j_reg      <= '0;
                rd_ptr_reg <= wp_reg;
                wp_reg     <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
            end
            else if (ctl.issue)
            begin
                j_reg      <= j_reg + AW'(1);
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - AW'(1);
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            sample_reg <= req.data.value;
        end
        if (out_load)
        begin
            out_data_reg.out_sample <= mix_sample;
            out_data_reg.clipped    <= mix_clipped;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;

    assign mem_wdata  = wr_clear ? '0 : req.data.value;
    assign coef_waddr = wr_clear ? clr_idx_reg : AW'(req.data.coef_index);
    assign hist_waddr = wr_clear ? clr_idx_reg : wp_reg;

    fcr_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .W     (fcr_pkg::SAMPLE_W)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (mem_wdata),
        .raddr (j_reg),
        .rdata (coef_rdata)
    );

    fcr_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .W     (fcr_pkg::SAMPLE_W)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (mem_wdata),
        .raddr (rd_ptr_reg),
        .rdata (hist_rdata)
    );

    fcr_mac #(
        .AW (AW)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .coef        ($signed(coef_rdata)),
        .hist        ($signed(hist_rdata)),
        .tail_gain   (tail_gain_reg),
        .direct_gain (direct_gain_reg),
        .sample      (sample_reg),
        .last_done   (last_done),
        .out_sample  (mix_sample),
        .clipped     (mix_clipped)
    );

    // a result only appears after the output stage of a sample
    a_rsp_from_ship: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == fcr_pkg::ST_SHIP))
        else $error("result appeared outside the output stage");

    // a load leaves the sequencer idle
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.data.cmd == fcr_pkg::CMD_LOAD)
        |=> state_reg == fcr_pkg::ST_IDLE)
        else $error("coefficient load started a sample pass");

    // the last product only lands while taps are issued or draining
    a_last_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        last_done |-> (state_reg == fcr_pkg::ST_MAC || state_reg == fcr_pkg::ST_DRAIN))
        else $error("last tap product outside the tap pass");

    // history pointer moves only on an accepted sample
    a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.valid && req.ready && req.data.cmd == fcr_pkg::CMD_SAMPLE)
        |=> $stable(wp_reg))
        else $error("write pointer moved without a sample transfer");

endmodule

FILE: sv/fcr_ram.sv
// fcr_ram: simple dual-port memory with registered read data
`timescale 1ns / 1ps

module fcr_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int W     = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/fcr_mac.sv
// fcr_mac: tap multiply-accumulate, wet/dry mix, rounding and saturation
`timescale 1ns / 1ps

module fcr_mac #(
    parameter int AW = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fcr_pkg::mac_ctl_t                   ctl,
    input  logic signed [fcr_pkg::SAMPLE_W-1:0] coef,
    input  logic signed [fcr_pkg::SAMPLE_W-1:0] hist,
    input  logic signed [fcr_pkg::GAIN_W-1:0]   tail_gain,
    input  logic signed [fcr_pkg::GAIN_W-1:0]   direct_gain,
    input  logic signed [fcr_pkg::SAMPLE_W-1:0] sample,
    output logic                                last_done,
    output logic signed [fcr_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                clipped
);

    localparam int SW    = fcr_pkg::PROD_W + AW;
    localparam int HI_W  = SW - fcr_pkg::LO_W;
    localparam int ACC_W = SW + fcr_pkg::GAIN_W + 1;
    localparam int QW    = ACC_W - fcr_pkg::FRAC_SHIFT;
    localparam int LO_PW = fcr_pkg::LO_W + 1 + fcr_pkg::GAIN_W;
    localparam int HI_PW = HI_W + fcr_pkg::GAIN_W;

    logic                             rd_vld_reg;
    logic                             rd_last_reg;
    logic                             prod_vld_reg;
    logic                             prod_last_reg;
    logic signed [fcr_pkg::PROD_W-1:0] prod_reg;
    logic signed [SW-1:0]             sum_reg;
    logic signed [LO_PW-1:0]          p_lo_reg;
    logic signed [HI_PW-1:0]          p_hi_reg;
    logic signed [fcr_pkg::PROD_W-1:0] dry_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          acc_next;
    logic signed [ACC_W-1:0]          rnd;
    logic signed [QW-1:0]             quo;
    logic                             fits;

    // rd tags line up with the registered memory read data, prod tags with the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg    <= ctl.issue;
            rd_last_reg   <= ctl.issue & ctl.issue_last;
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * hist;
        if (ctl.clear)
        begin
            sum_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            sum_reg <= sum_reg + SW'(prod_reg);
        end
        // wet gain split into two narrow products
        if (ctl.gain_step)
        begin
            p_lo_reg <= $signed({1'b0, sum_reg[fcr_pkg::LO_W-1:0]}) * tail_gain;
            p_hi_reg <= $signed(sum_reg[SW-1:fcr_pkg::LO_W]) * tail_gain;
            dry_reg  <= sample * direct_gain;
        end
        if (ctl.sum_step)
        begin
            acc_reg <= acc_next;
        end
    end

    assign last_done = prod_vld_reg & prod_last_reg;

    always_comb
    begin
        acc_next = (ACC_W'(p_hi_reg) <<< fcr_pkg::LO_W) + ACC_W'(p_lo_reg)
                 + (ACC_W'(dry_reg) <<< fcr_pkg::DRY_SHIFT);
    end

    // round half up, then floor shift
    always_comb
    begin
        rnd  = acc_reg + (ACC_W'(1) <<< (fcr_pkg::FRAC_SHIFT - 1));
        quo  = rnd[ACC_W-1:fcr_pkg::FRAC_SHIFT];
        fits = (&quo[QW-1:fcr_pkg::SAMPLE_W-1]) | ~(|quo[QW-1:fcr_pkg::SAMPLE_W-1]);
        if (fits)
        begin
            out_sample = quo[fcr_pkg::SAMPLE_W-1:0];
        end
        else if (quo[QW-1])
        begin
            out_sample = fcr_pkg::SAT_MIN;
        end
        else
        begin
            out_sample = fcr_pkg::SAT_MAX;
        end
        clipped = ~fits;
    end

endmodule

FILE: bench/tb_fir_convolution_reverb.sv
// tb_fir_convolution_reverb: self-checking bench for the convolution reverb block
`timescale 1ns / 1ps

module tb_fir_convolution_reverb;

    localparam int TAPS         = 1024;
    localparam int ITEM_TARGET  = 580;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int PLAN_ROWS    = 37;
    localparam int PRESSURE_PH  = 2;

    localparam int SAMPLE_W  = fcr_pkg::SAMPLE_W;
    localparam int GAIN_W    = fcr_pkg::GAIN_W;
    localparam int TAPS_W    = fcr_pkg::TAPS_W;
    localparam int IDX_W     = fcr_pkg::IDX_W;
    localparam int REG_IDX_W = fcr_pkg::REG_IDX_W;

    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_SAMPLE,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [IDX_W-1:0]    addr;
        logic [SAMPLE_W-1:0] value;
        logic                typed;
        logic [SAMPLE_W-1:0] exp_sample;
        logic                exp_clip;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    fcr_stream_if #(.T(fcr_pkg::in_item_t))  req_if ();
    fcr_stream_if #(.T(fcr_pkg::out_item_t)) rsp_if ();

    fir_convolution_reverb #(.TAPS(TAPS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow state of the reverb
    logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
    logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
    int unsigned                wr_ptr;
    logic signed [GAIN_W-1:0]   tail_reg;
    logic signed [GAIN_W-1:0]   dry_reg;
    logic [TAPS_W-1:0]          taps_reg;

    fcr_pkg::out_item_t expected_out [$];
    fcr_pkg::out_item_t want;

    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned samples_sent;
    int unsigned loads_sent;
    int unsigned reg_writes;
    int unsigned results_seen;
    int unsigned clip_seen;
    int unsigned burst_left;
    int unsigned phase_count;
    bit          hold_request;

    // zero and values above the store length are clamped
    function automatic int unsigned active_taps();
        if (taps_reg == '0)
            return 1;
        if (taps_reg > TAPS)
            return TAPS;
        return 32'(taps_reg);
    endfunction

    function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [GAIN_W-1:0] data);
        case (idx)
            fcr_pkg::REG_TAIL_GAIN:   tail_reg = data;
            fcr_pkg::REG_DIRECT_GAIN: dry_reg = data;
            fcr_pkg::REG_TAPS_IN_USE: taps_reg = data[TAPS_W-1:0];
            default: ;
        endcase
    endfunction

    // returns 1 when the item yields an output sample
    function automatic bit reverb_step(input fcr_pkg::in_item_t it,
                                       output fcr_pkg::out_item_t res);
        longint      tap_sum;
        longint      mixed;
        longint      rounded;
        int unsigned m;
        int unsigned j;
        int unsigned pos;
        res = '0;
        if (it.cmd == fcr_pkg::CMD_LOAD)
        begin
            coef_mem[it.coef_index] = it.value;
            return 1'b0;
        end
        hist_mem[wr_ptr] = it.value;
        m = active_taps();
        tap_sum = 0;
        for (j = 0; j < m; j++)
        begin
            pos = (wr_ptr + TAPS - j) % TAPS;
            tap_sum += longint'(coef_mem[j]) * longint'(hist_mem[pos]);
        end
        mixed = tap_sum * longint'(tail_reg)
              + longint'($signed(it.value)) * longint'(dry_reg)
                * (longint'(1) << fcr_pkg::DRY_SHIFT);
        // floor after adding half, so ties go up
        rounded = (mixed + (longint'(1) << (fcr_pkg::FRAC_SHIFT - 1)))
                  >>> fcr_pkg::FRAC_SHIFT;
        if (rounded > longint'(fcr_pkg::SAT_MAX))
        begin
            res.out_sample = fcr_pkg::SAT_MAX;
            res.clipped = 1'b1;
        end
        else if (rounded < longint'(fcr_pkg::SAT_MIN))
        begin
            res.out_sample = fcr_pkg::SAT_MIN;
            res.clipped = 1'b1;
        end
        else
        begin
            res.out_sample = rounded[SAMPLE_W-1:0];
        end
        wr_ptr = (wr_ptr + 1) % TAPS;
        return 1'b1;
    endfunction

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_SAMPLE, 10'h000, 16'h7fff, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h3ff, 16'h8000, 1'b1, 16'h0000, 1'b0},
        '{ROW_LOAD,   10'h000, 16'h7fff, 1'b0, 16'h0000, 1'b0},
        '{ROW_LOAD,   10'h3ff, 16'h8000, 1'b0, 16'h0000, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_TAIL_GAIN),   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_DIRECT_GAIN), 16'h1000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h155, 16'h7fff, 1'b1, 16'h7fff, 1'b0},
        '{ROW_SAMPLE, 10'h2aa, 16'h8000, 1'b1, 16'h8000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h1234, 1'b1, 16'h1234, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_DIRECT_GAIN), 16'h7fff, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h7fff, 1'b1, 16'h7fff, 1'b1},
        '{ROW_SAMPLE, 10'h000, 16'h8000, 1'b1, 16'h8000, 1'b1},
        '{ROW_SAMPLE, 10'h000, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_DIRECT_GAIN), 16'h8000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h8000, 1'b1, 16'h7fff, 1'b1},
        '{ROW_SAMPLE, 10'h000, 16'h0001, 1'b1, 16'hfff8, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_DIRECT_GAIN), 16'h0001, 1'b0, 16'h0000, 1'b0},
        // exact halves: +0.5 goes up, -0.5 goes up to zero
        '{ROW_SAMPLE, 10'h000, 16'h0800, 1'b1, 16'h0001, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'hf800, 1'b1, 16'h0000, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_DIRECT_GAIN), 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_TAIL_GAIN),   16'h1000, 1'b0, 16'h0000, 1'b0},
        // zero taps runs a single tap
        '{ROW_REG, IDX_W'(fcr_pkg::REG_TAPS_IN_USE), 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h7fff, 1'b1, 16'h7ffe, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h8000, 1'b1, 16'h8001, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_TAIL_GAIN),   16'h7fff, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h7fff, 1'b1, 16'h7fff, 1'b1},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_TAIL_GAIN),   16'h8000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h8000, 1'b1, 16'h7fff, 1'b1},
        '{ROW_SAMPLE, 10'h000, 16'h7fff, 1'b1, 16'h8000, 1'b1},
        // taps above the store length act as the full store
        '{ROW_REG, IDX_W'(fcr_pkg::REG_TAPS_IN_USE), 16'h07ff, 1'b0, 16'h0000, 1'b0},
        '{ROW_REG, IDX_W'(REG_UNMAPPED),             16'h5a5a, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h1ff, 16'h4000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'hc000, 1'b0, 16'h0000, 1'b0},
        '{ROW_LOAD,   10'h200, 16'h1111, 1'b0, 16'h0000, 1'b0},
        '{ROW_REG, IDX_W'(fcr_pkg::REG_TAPS_IN_USE), 16'h0002, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h000, 16'h2000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 10'h3ff, 16'he000, 1'b0, 16'h0000, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // offers one item until the transfer, then books its expected output
    task automatic push_item(input fcr_pkg::in_item_t it, input bit typed,
                             input fcr_pkg::out_item_t typed_res);
        fcr_pkg::out_item_t res;
        bit                 has_res;
        req_if.valid <= 1'b1;
        req_if.data  <= it;
        do
            @(posedge clk);
        while (!req_if.ready);
        has_res = reverb_step(it, res);
        if (has_res)
            expected_out.push_back(typed ? typed_res : res);
        items_sent++;
        if (it.cmd == fcr_pkg::CMD_SAMPLE)
            samples_sent++;
        else
            loads_sent++;
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // a load gives no output, so also wait out the SETTLE margin past the last result
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h1000;
            3: return 16'h0000;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // response side: random stall segments plus one long hold on request
    initial
    begin
        int unsigned hold_left;
        int unsigned seg_left;
        int unsigned seg_mode;
        hold_left = 0;
        seg_left = 0;
        seg_mode = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (seg_mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
                    default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_seen++;
            if (rsp_if.data.clipped === 1'b1)
                clip_seen++;
            if (expected_out.size() == 0)
            begin
                $error("output transfer with no sample pending: out_sample %0d",
                       $signed(rsp_if.data.out_sample));
                fail_count++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (rsp_if.data.out_sample !== want.out_sample)
                begin
                    $error("out_sample: expected %0d, got %0d",
                           $signed(want.out_sample), $signed(rsp_if.data.out_sample));
                    fail_count++;
                end
                if (rsp_if.data.clipped !== want.clipped)
                begin
                    $error("clipped: expected %0b, got %0b",
                           want.clipped, rsp_if.data.clipped);
                    fail_count++;
                end
            end
        end
    end

    // ends the run when no transfer happens for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
        $display("FAIL fir_convolution_reverb");
        $finish;
    end

    initial
    begin
        fcr_pkg::in_item_t it;
        logic [GAIN_W-1:0] taps_word;
        int unsigned       n_items;
        int unsigned       k;
        bit                full_len;
        bit                pressure;

        req_if.valid = 1'b0;
        req_if.data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_request = 1'b0;
        burst_left = 0;
        tail_reg = fcr_pkg::TAIL_GAIN_RST;
        dry_reg = fcr_pkg::DIRECT_GAIN_RST;
        taps_reg = fcr_pkg::TAPS_IN_USE_RST;
        wr_ptr = 0;
        for (k = 0; k < TAPS; k++)
        begin
            coef_mem[k] = '0;
            hist_mem[k] = '0;
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // both memories are cleared before the first transfer is taken
        do
            @(posedge clk);
        while (!req_if.ready);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(plan[i].addr[REG_IDX_W-1:0], plan[i].value);
            end
            else
            begin
                it.cmd = (plan[i].kind == ROW_SAMPLE) ? fcr_pkg::CMD_SAMPLE
                                                      : fcr_pkg::CMD_LOAD;
                it.coef_index = plan[i].addr;
                it.value = plan[i].value;
                push_item(it, plan[i].typed, {plan[i].exp_sample, plan[i].exp_clip});
                pace_sender();
            end
        end

        phase_count = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            phase_count++;
            pressure = (phase_count == PRESSURE_PH);
            full_len = !pressure && (phase_count % 7 == 3);
            if (phase_count == 1 || $urandom_range(0, 2) != 0)
                write_reg(fcr_pkg::REG_TAIL_GAIN, pick_gain());
            if (phase_count == 1 || $urandom_range(0, 2) != 0)
                write_reg(fcr_pkg::REG_DIRECT_GAIN, pick_gain());
            // junk above the taps field must be dropped
            taps_word = GAIN_W'($urandom);
            if (full_len)
                taps_word[TAPS_W-1:0] = ($urandom_range(0, 1) == 1) ? TAPS_W'(TAPS)
                                        : TAPS_W'($urandom_range(TAPS + 1, 2047));
            else if ($urandom_range(0, 3) == 0)
                taps_word[TAPS_W-1:0] = TAPS_W'($urandom_range(0, 2));
            else
                taps_word[TAPS_W-1:0] = TAPS_W'($urandom_range(3, 24));
            write_reg(fcr_pkg::REG_TAPS_IN_USE, taps_word);
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_UNMAPPED, GAIN_W'($urandom));

            n_items = full_len ? $urandom_range(3, 6) : $urandom_range(10, 40);
            if (pressure)
            begin
                n_items = 16;
                hold_request = 1'b1;
            end
            for (k = 0; k < n_items; k++)
            begin
                it.coef_index = IDX_W'($urandom_range(0, TAPS - 1));
                it.value = pick_value();
                if (!pressure && $urandom_range(0, 3) == 0)
                begin
                    it.cmd = fcr_pkg::CMD_LOAD;
                    // mostly inside the taps in use so the loads show up in the sum
                    if ($urandom_range(0, 3) != 0)
                        it.coef_index = IDX_W'($urandom_range(0, active_taps() - 1));
                    it.value = SAMPLE_W'($urandom);
                end
                else
                begin
                    it.cmd = fcr_pkg::CMD_SAMPLE;
                end
                push_item(it, 1'b0, '0);
                if (!pressure)
                    pace_sender();
            end
        end

        wait_idle();
        repeat (TAPS + 16) @(posedge clk);
        $display("ran %0d samples and %0d coefficient loads across %0d random phases",
                 samples_sent, loads_sent, phase_count);
        $display("%0d register writes, %0d outputs checked, %0d of them saturated",
                 reg_writes, results_seen, clip_seen);
        if (fail_count == 0)
            $display("PASS fir_convolution_reverb");
        else
            $display("FAIL fir_convolution_reverb");
        $finish;
    end

endmodule
